[sv/leb_pkg.sv]
package leb_pkg;

    // Line capacity and the widths that follow from it.
    localparam int LINE_LEN = 256;
    localparam int IDX_W    = $clog2(LINE_LEN);
    localparam int LEN_W    = $clog2(LINE_LEN + 1);
    localparam int CHAR_W   = 8;

    // Operation codes.
    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_BACKSPACE = 2'd1;
    localparam logic [1:0] OP_DELETE    = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_BOUNDARY = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_UNKNOWN  = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_INS,
        S_FETCH,
        S_WAIT
    } state_t;

    // Access request from the sequencer to the line store.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    // One finished result.
    typedef struct packed {
        logic [1:0]        status;
        logic [LEN_W-1:0]  line_length;
        logic [LEN_W-1:0]  new_cursor;
        logic [CHAR_W-1:0] char_at_cursor;
    } res_t;

endpackage

[sv/line_edit_buffer_top.sv]
// Sequence: after an input transfer the sequencer walks the characters the edit moves
// through the line store one cell per cycle, writes the new character (insert only),
// reads the character at the new cursor and hands the result to the output register
// once that register is free. One item is in work at a time; the next item is taken
// after the previous result has gone into the output register. A new item is taken
// while the previous result still waits in the output register.
// Reset (rst_n, asynchronous, active low) clears the length and the control state;
// the line store itself is not cleared.
module line_edit_buffer_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic [leb_pkg::CHAR_W-1:0] char_in,
    input  logic [leb_pkg::LEN_W-1:0]  cursor_pos,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic [leb_pkg::LEN_W-1:0]  line_length,
    output logic [leb_pkg::LEN_W-1:0]  new_cursor,
    output logic [leb_pkg::CHAR_W-1:0] char_at_cursor
);

    import leb_pkg::*;

    mem_req_t           mem_req;
    res_t               result;
    res_t               res_reg;
    logic               out_valid_reg;
    logic               done;
    logic               out_free;
    logic [CHAR_W-1:0]  rd_data;

    assign out_free = !out_valid_reg || out_ready;

    leb_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .char_in    (char_in),
        .cursor_pos (cursor_pos),
        .out_free   (out_free),
        .done       (done),
        .result     (result),
        .mem_req    (mem_req),
        .rd_data    (rd_data)
    );

    leb_ram #(
        .DEPTH (LINE_LEN),
        .WIDTH (CHAR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rd_data)
    );

    // Output register: holds a result until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            res_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = res_reg.status;
    assign line_length    = res_reg.line_length;
    assign new_cursor     = res_reg.new_cursor;
    assign char_at_cursor = res_reg.char_at_cursor;

endmodule

[sv/leb_ram.sv]
module leb_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/leb_seq.sv]
module leb_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 op,
    input  logic [leb_pkg::CHAR_W-1:0] char_in,
    input  logic [leb_pkg::LEN_W-1:0]  cursor_pos,
    input  logic                       out_free,
    output logic                       done,
    output leb_pkg::res_t              result,
    output leb_pkg::mem_req_t          mem_req,
    input  logic [leb_pkg::CHAR_W-1:0] rd_data
);

    import leb_pkg::*;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   ncur_reg, ncur_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]         st_reg, st_next;
    logic               ins_reg, ins_next;
    logic               up_reg, up_next;
    logic               pend_reg, pend_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   rd_addr_reg, rd_addr_next;
    logic [IDX_W-1:0]   wr_addr_reg, wr_addr_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [CHAR_W-1:0]  ch_reg, ch_next;

    logic               accept;
    logic [LEN_W-1:0]   clamp;

    assign accept = in_valid && (state_reg == S_IDLE);
    assign clamp  = (cursor_pos > len_reg) ? len_reg : cursor_pos;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ins_reg ? S_INS : S_FETCH;
                end
            end
            S_INS:   state_next = S_FETCH;
            S_FETCH: state_next = S_WAIT;
            S_WAIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs: handshake and memory access.
    always_comb
    begin
        in_ready      = 1'b0;
        done          = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = wr_addr_reg;
        mem_req.wdata = rd_data;
        mem_req.re    = 1'b0;
        mem_req.raddr = rd_addr_reg;
        case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_SHIFT:
            begin
                mem_req.we = pend_reg;
                mem_req.re = (cnt_reg != '0);
            end
            S_INS:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cur_reg;
                mem_req.wdata = ch_reg;
            end
            S_FETCH:
            begin
                mem_req.re    = (ncur_reg < len_reg);
                mem_req.raddr = ncur_reg[IDX_W-1:0];
            end
            S_WAIT:  done = out_free;
            default: in_ready = 1'b0;
        endcase
    end

    assign result.status         = st_reg;
    assign result.line_length    = len_reg;
    assign result.new_cursor     = ncur_reg;
    assign result.char_at_cursor = hit_reg ? rd_data : '0;

    // Datapath next values: operation decode on transfer, walk of the tail after it.
    always_comb
    begin
        len_next     = len_reg;
        ncur_next    = ncur_reg;
        cnt_next     = cnt_reg;
        st_next      = st_reg;
        ins_next     = ins_reg;
        up_next      = up_reg;
        pend_next    = pend_reg;
        hit_next     = hit_reg;
        rd_addr_next = rd_addr_reg;
        wr_addr_next = wr_addr_reg;
        cur_next     = cur_reg;
        ch_next      = ch_reg;
        if (accept)
        begin
            ch_next   = char_in;
            cur_next  = clamp[IDX_W-1:0];
            ncur_next = clamp;
            cnt_next  = '0;
            ins_next  = 1'b0;
            up_next   = 1'b0;
            pend_next = 1'b0;
            st_next   = ST_DONE;
            case (op)
                OP_INSERT:
                begin
                    if (len_reg >= LEN_W'(LINE_LEN))
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        cnt_next     = len_reg - clamp;
                        rd_addr_next = IDX_W'(len_reg - LEN_W'(1));
                        up_next      = 1'b1;
                        ins_next     = 1'b1;
                        ncur_next    = clamp + LEN_W'(1);
                        len_next     = len_reg + LEN_W'(1);
                    end
                end
                OP_BACKSPACE:
                begin
                    if (clamp == '0)
                    begin
                        st_next = ST_BOUNDARY;
                    end
                    else
                    begin
                        cnt_next     = len_reg - clamp;
                        rd_addr_next = clamp[IDX_W-1:0];
                        ncur_next    = clamp - LEN_W'(1);
                        len_next     = len_reg - LEN_W'(1);
                    end
                end
                OP_DELETE:
                begin
                    if (clamp >= len_reg)
                    begin
                        st_next = ST_BOUNDARY;
                    end
                    else
                    begin
                        cnt_next     = len_reg - clamp - LEN_W'(1);
                        rd_addr_next = IDX_W'(clamp + LEN_W'(1));
                        len_next     = len_reg - LEN_W'(1);
                    end
                end
                default: st_next = ST_UNKNOWN;
            endcase
        end
        else if (state_reg == S_SHIFT)
        begin
            // One cell per cycle: read the next source, write the previous one.
            if (cnt_reg != '0)
            begin
                pend_next    = 1'b1;
                cnt_next     = cnt_reg - LEN_W'(1);
                wr_addr_next = up_reg ? rd_addr_reg + IDX_W'(1) : rd_addr_reg - IDX_W'(1);
                rd_addr_next = up_reg ? rd_addr_reg - IDX_W'(1) : rd_addr_reg + IDX_W'(1);
            end
            else
            begin
                pend_next = 1'b0;
            end
        end
        else if (state_reg == S_FETCH)
        begin
            hit_next = (ncur_reg < len_reg);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ncur_reg    <= ncur_next;
        cnt_reg     <= cnt_next;
        st_reg      <= st_next;
        ins_reg     <= ins_next;
        up_reg      <= up_next;
        hit_reg     <= hit_next;
        rd_addr_reg <= rd_addr_next;
        wr_addr_reg <= wr_addr_next;
        cur_reg     <= cur_next;
        ch_reg      <= ch_next;
    end

endmodule

[sv/leb_chk.sv]
module leb_chk (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [1:0]                 status,
    input logic [leb_pkg::LEN_W-1:0]  line_length,
    input logic [leb_pkg::LEN_W-1:0]  new_cursor,
    input logic [leb_pkg::CHAR_W-1:0] char_at_cursor
);

    import leb_pkg::*;

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(line_length)
            && $stable(new_cursor) && $stable(char_at_cursor))
        else $error("result changed while stalled");

    // The cursor never passes the end of the line, and the line never passes capacity.
    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> new_cursor <= line_length && line_length <= LEN_W'(LINE_LEN))
        else $error("cursor or length out of range");

    // A full report only comes from a full line.
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> line_length == LEN_W'(LINE_LEN))
        else $error("line full reported below capacity");

    // A cursor at the end of the line shows no character.
    a_end_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_cursor == line_length |-> char_at_cursor == '0)
        else $error("character shown past end of line");

    // Only one item is in work at a time, so an input transfer drops ready.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

endmodule

bind line_edit_buffer_top leb_chk u_chk (.*);

[bench/tb_line_edit_buffer_top.sv]
module tb_line_edit_buffer_top;

    timeunit 1ns;
    timeprecision 1ps;

    import leb_pkg::*;

    // Operation code with no defined edit behind it.
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    localparam int RANDOM_EDITS = 1400;
    localparam int CALM_EDITS   = 200;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 300;

    // Shadow copy of the line: predicts every reply from the edits accepted so far.
    class line_shadow;
        logic [CHAR_W-1:0] cells [LINE_LEN];
        int                length;
        res_t              replies [$];
        int                mismatches;
        int                reply_count;

        function new();
            length      = 0;
            mismatches  = 0;
            reply_count = 0;
        endfunction

        // Close the hole left by a removed character and shorten the line.
        function void close_gap(int pos);
            int i;
            for (i = pos; i + 1 < length; i++)
                cells[i] = cells[i + 1];
            length--;
        endfunction

        // Apply one accepted edit and queue the reply it must produce.
        function void apply_edit(logic [1:0] op_code, logic [CHAR_W-1:0] ch,
                                 logic [LEN_W-1:0] pos);
            int   cur;
            int   i;
            res_t r;
            cur = (int'(pos) > length) ? length : int'(pos);
            r.status = ST_DONE;
            case (op_code)
                OP_INSERT:
                begin
                    if (length >= LINE_LEN)
                        r.status = ST_FULL;
                    else
                    begin
                        for (i = length; i > cur; i--)
                            cells[i] = cells[i - 1];
                        cells[cur] = ch;
                        length++;
                        cur++;
                    end
                end
                OP_BACKSPACE:
                begin
                    if (cur == 0)
                        r.status = ST_BOUNDARY;
                    else
                    begin
                        cur--;
                        close_gap(cur);
                    end
                end
                OP_DELETE:
                begin
                    if (cur >= length)
                        r.status = ST_BOUNDARY;
                    else
                        close_gap(cur);
                end
                default:
                    r.status = ST_UNKNOWN;
            endcase
            r.line_length    = LEN_W'(length);
            r.new_cursor     = LEN_W'(cur);
            r.char_at_cursor = (cur < length) ? cells[cur] : '0;
            replies.push_back(r);
        endfunction

        // Compare one transferred reply with the oldest prediction.
        function void check_reply(res_t got);
            res_t want;
            reply_count++;
            if (replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply %0d with nothing predicted: st %0d len %0d cur %0d ch %02h",
                             reply_count, got.status, got.line_length, got.new_cursor,
                             got.char_at_cursor);
                return;
            end
            want = replies.pop_front();
            if (got.status !== want.status || got.line_length !== want.line_length ||
                got.new_cursor !== want.new_cursor ||
                got.char_at_cursor !== want.char_at_cursor)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply %0d: expected st %0d len %0d cur %0d ch %02h, got st %0d len %0d cur %0d ch %02h",
                             reply_count, want.status, want.line_length, want.new_cursor,
                             want.char_at_cursor, got.status, got.line_length,
                             got.new_cursor, got.char_at_cursor);
            end
        endfunction

        function int outstanding();
            return replies.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        op;
    logic [CHAR_W-1:0] char_in;
    logic [LEN_W-1:0]  cursor_pos;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        status;
    logic [LEN_W-1:0]  line_length;
    logic [LEN_W-1:0]  new_cursor;
    logic [CHAR_W-1:0] char_at_cursor;

    line_shadow shadow = new();
    bit         calm = 1'b0;
    int         cycle_count = 0;

    line_edit_buffer_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .char_in        (char_in),
        .cursor_pos     (cursor_pos),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .line_length    (line_length),
        .new_cursor     (new_cursor),
        .char_at_cursor (char_at_cursor)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Overall cycle limit in case the block hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** line_edit_buffer_top: FAILED **");
        $finish;
    end

    // Receiver: random stall bursts between ready stretches, always ready once calm.
    initial
    begin
        int run;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (calm)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                run = $urandom_range(1, 6);
                out_ready <= 1'b0;
                repeat (run) @(posedge clk);
                run = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(1, 12);
                out_ready <= 1'b1;
                repeat (run) @(posedge clk);
            end
        end
    end

    // Check every reply transfer against the shadow line.
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.status         = status;
            got.line_length    = line_length;
            got.new_cursor     = new_cursor;
            got.char_at_cursor = char_at_cursor;
            shadow.check_reply(got);
        end
    end

    // Offer one edit after an optional gap and wait for its transfer.
    // With settle set, the sender first waits until every reply has come back.
    task automatic send_edit(logic [1:0] op_code, logic [CHAR_W-1:0] ch,
                             logic [LEN_W-1:0] pos, int gap, bit settle);
        if (gap > 0 || settle)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            if (settle)
            begin
                do
                    @(posedge clk);
                while (shadow.outstanding() != 0);
            end
        end
        in_valid   <= 1'b1;
        op         <= op_code;
        char_in    <= ch;
        cursor_pos <= pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        shadow.apply_edit(op_code, ch, pos);
    endtask

    // Stimulus: directed edge cases, then random fill and drain cycles.
    initial
    begin
        logic [1:0]        op_code;
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  pos;
        int                pick;
        int                gap;
        bit                filling;
        bit                sparse;
        int                n;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        op         <= OP_INSERT;
        char_in    <= '0;
        cursor_pos <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Removals and an unknown code on an empty line.
        send_edit(OP_BACKSPACE, 8'h00, 9'd0,   0, 1'b0);
        send_edit(OP_DELETE,    8'hFF, 9'd0,   1, 1'b0);
        send_edit(OP_DELETE,    8'h11, 9'd256, 0, 1'b0);
        send_edit(OP_UNKNOWN,   8'hFF, 9'd256, 0, 1'b0);
        // Inserts at the start, past the end (clamped) and in the middle; zero byte too.
        send_edit(OP_INSERT,    8'h00, 9'd0,   0, 1'b0);
        send_edit(OP_INSERT,    8'hFF, 9'd256, 2, 1'b0);
        send_edit(OP_INSERT,    8'hA5, 9'd0,   0, 1'b0);
        send_edit(OP_INSERT,    8'h5A, 9'd1,   0, 1'b0);
        send_edit(OP_INSERT,    8'h80, 9'd200, 0, 1'b0);
        send_edit(OP_INSERT,    8'h01, 9'd3,   1, 1'b0);
        // Deletes at the start, in the middle and at the end.
        send_edit(OP_DELETE,    8'h00, 9'd0,   0, 1'b0);
        send_edit(OP_DELETE,    8'h00, 9'd2,   0, 1'b0);
        send_edit(OP_DELETE,    8'h00, 9'd256, 0, 1'b0);
        // Backspaces past the end, in the middle and at the start.
        send_edit(OP_BACKSPACE, 8'h00, 9'd256, 0, 1'b0);
        send_edit(OP_BACKSPACE, 8'h00, 9'd1,   0, 1'b0);
        send_edit(OP_BACKSPACE, 8'h00, 9'd0,   0, 1'b0);
        send_edit(OP_UNKNOWN,   8'h00, 9'd0,   0, 1'b0);
        send_edit(OP_INSERT,    8'h7E, 9'd255, 0, 1'b0);

        // Random part: grow the line until full, then shrink it back, and repeat.
        filling = 1'b1;
        sparse  = 1'b1;
        for (n = 0; n < RANDOM_EDITS; n++)
        begin
            if (n == RANDOM_EDITS - CALM_EDITS)
                calm = 1'b1;
            if (n % 64 == 0)
                sparse = $urandom_range(0, 2) != 0;
            if (filling && shadow.length == LINE_LEN && $urandom_range(0, 5) == 0)
                filling = 1'b0;
            else if (!filling && shadow.length == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;

            // Operation mix depends on whether the line is growing or shrinking.
            pick = $urandom_range(0, 99);
            if (filling)
                op_code = (pick < 75) ? OP_INSERT : (pick < 85) ? OP_BACKSPACE :
                          (pick < 95) ? OP_DELETE : OP_UNKNOWN;
            else
                op_code = (pick < 12) ? OP_INSERT : (pick < 52) ? OP_BACKSPACE :
                          (pick < 92) ? OP_DELETE : OP_UNKNOWN;

            // Character with extra weight on the extreme bytes.
            case ($urandom_range(0, 9))
                0:       ch = 8'h00;
                1:       ch = 8'hFF;
                default: ch = CHAR_W'($urandom_range(0, 255));
            endcase

            // Cursor mostly inside the line, sometimes at its ends or beyond.
            case ($urandom_range(0, 9))
                0:       pos = 9'd0;
                1:       pos = 9'd256;
                2:       pos = LEN_W'(shadow.length);
                3:       pos = LEN_W'($urandom_range(0, 256));
                default: pos = LEN_W'($urandom_range(0, shadow.length));
            endcase

            gap = (!calm && sparse && $urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            send_edit(op_code, ch, pos, gap, n == RANDOM_EDITS / 2);
        end
        in_valid <= 1'b0;

        // Let every outstanding reply arrive, then watch for stray ones.
        while (shadow.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (shadow.mismatches == 0 && shadow.outstanding() == 0)
            $display("** line_edit_buffer_top: PASSED **");
        else
            $display("** line_edit_buffer_top: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
sv/leb_pkg.sv
sv/leb_ram.sv
sv/leb_seq.sv
sv/line_edit_buffer_top.sv
sv/leb_chk.sv
bench/tb_line_edit_buffer_top.sv
